// ----- sv/pcs_pkg.sv -----
// ----------------------------------------------------------------------------
// pcs_pkg: shared types and constants for the polygon corner block
// Widths of the line coefficients, accumulator and divider, and the
// command/status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package pcs_pkg;

  // Pixel coordinate width and fraction bits of the corner outputs.
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 8;

  // Line a*x + b*y = c: a and b are coordinate differences, c is a sum of two products.
  localparam int A_W    = COORD_BITS + 1;
  localparam int C_W    = 2 * COORD_BITS + 3;
  localparam int DET_W  = C_W;
  localparam int NUM_W  = 3 * COORD_BITS + 4;
  localparam int PROD_W = C_W + A_W;

  // Corner output and divider widths.
  localparam int OUT_W = 32;
  localparam int QW    = OUT_W + 1;
  localparam int DVD_W = NUM_W + FRAC_BITS;
  localparam int CNT_W = $clog2(QW + 1);

  // Operand pairs for the shared multiplier.
  typedef enum logic [2:0] {
    MUL_AX,
    MUL_BY,
    MUL_PA_QB,
    MUL_QA_PB,
    MUL_PC_QB,
    MUL_QC_PB,
    MUL_QC_PA,
    MUL_PC_QA
  } mul_sel_t;

  // Accumulator operations on the registered product.
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  // Which two lines form the current corner.
  typedef enum logic {
    PAIR_PREV_CUR,
    PAIR_CUR_FIRST
  } pair_sel_t;

  // Which numerator goes to the divider.
  typedef enum logic {
    DIV_X,
    DIV_Y
  } div_sel_t;

  typedef struct packed {
    logic      cap;
    mul_sel_t  mul_sel;
    acc_op_t   acc_op;
    logic      store_c;
    logic      store_det;
    logic      store_nx;
    logic      store_ny;
    logic      set_first;
    logic      set_prev;
    logic      pair_load;
    pair_sel_t pair_sel;
    logic      corner_clear;
    logic      div_start;
    div_sel_t  div_sel;
    logic      cap_x;
    logic      cap_y;
    logic      out_load;
  } pcs_cmd_t;

  typedef struct packed {
    logic      final_seg;
    logic      det_zero;
    logic      div_done;
    pair_sel_t pair_sel;
  } pcs_stat_t;

endpackage

// ----- sv/pcs_div.sv -----
// ----------------------------------------------------------------------------
// pcs_div: serial fixed-point divider
// Computes the truncated quotient num * 2^FRAC_BITS / den, one quotient bit
// per cycle, saturated to the signed 32-bit range.
// ----------------------------------------------------------------------------
module pcs_div import pcs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DET_W-1:0] den,
  output logic                    done,
  output logic signed [OUT_W-1:0] quo,
  output logic                    sat
);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [DET_W-1:0] rem_r;
  logic [QW-1:0]    q_r;
  logic [DET_W-1:0] ud_r;
  logic             neg_r;

  logic                    neg_w;
  logic [NUM_W-1:0]        un;
  logic [DET_W-1:0]        ud;
  logic [DVD_W-1:0]        dvd;
  logic [DVD_W+QW-1:0]     ext;
  logic [DVD_W-1:0]        high;
  logic [QW-1:0]           low;
  logic                    ovf;
  logic [DET_W:0]          rem_s;
  logic [DET_W:0]          rem_dif;
  logic                    ge;
  logic [DET_W-1:0]        rem_nxt;
  logic [QW-1:0]           lim;
  logic [QW-1:0]           magc;
  logic [OUT_W-1:0]        m;

  // Operand magnitudes and the scaled dividend split at the quotient width.
  always_comb begin
    neg_w = num[NUM_W-1] ^ den[DET_W-1];
    un    = num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
    ud    = den[DET_W-1] ? (~den + DET_W'(1)) : den;
    dvd   = DVD_W'(un) << FRAC_BITS;
    ext   = (DVD_W + QW)'(dvd);
    high  = ext[DVD_W+QW-1:QW];
    low   = ext[QW-1:0];
    // A quotient that does not fit in QW bits is saturated outright.
    ovf   = high >= DVD_W'(ud);
  end

  // One restoring step: shift in the next dividend bit and try the subtract.
  always_comb begin
    rem_s   = {rem_r, q_r[QW-1]};
    rem_dif = rem_s - {1'b0, ud_r};
    ge      = rem_s >= {1'b0, ud_r};
    rem_nxt = ge ? rem_dif[DET_W-1:0] : rem_s[DET_W-1:0];
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (ovf) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= CNT_W'(QW);
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register; quotient bits enter from the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= neg_w;
      ud_r  <= ud;
      if (ovf) begin
        q_r <= '1;
      end else begin
        rem_r <= high[DET_W-1:0];
        q_r   <= low;
      end
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[QW-2:0], ge};
    end
  end

  // Clamp to the signed range and apply the sign.
  always_comb begin
    lim  = neg_r ? (QW'(1) << (OUT_W - 1)) : ((QW'(1) << (OUT_W - 1)) - QW'(1));
    sat  = q_r > lim;
    magc = sat ? lim : q_r;
    m    = magc[OUT_W-1:0];
    quo  = neg_r ? (~m + OUT_W'(1)) : m;
  end

  assign done = done_r;

endmodule

// ----- sv/pcs_dp.sv -----
// ----------------------------------------------------------------------------
// pcs_dp: datapath of the polygon corner block
// Line registers, shared multiplier with accumulator, Cramer terms, serial
// divider and the output register, all steered by controller commands.
// ----------------------------------------------------------------------------
module pcs_dp import pcs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pcs_cmd_t                cmd,
  output pcs_stat_t               stat,
  input  logic [COORD_BITS-1:0]   in_start_x,
  input  logic [COORD_BITS-1:0]   in_start_y,
  input  logic [COORD_BITS-1:0]   in_end_x,
  input  logic [COORD_BITS-1:0]   in_end_y,
  input  logic                    in_final_segment,
  output logic signed [OUT_W-1:0] out_corner_x,
  output logic signed [OUT_W-1:0] out_corner_y,
  output logic                    out_parallel_flag,
  output logic                    out_saturated_flag,
  output logic                    out_last_corner
);

  logic signed [A_W-1:0]    cur_a_r, cur_b_r, prev_a_r, prev_b_r, first_a_r, first_b_r;
  logic signed [C_W-1:0]    cur_c_r, prev_c_r, first_c_r;
  logic [COORD_BITS-1:0]    x1_r, y1_r;
  logic                     final_r;
  pair_sel_t                pair_sel_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [NUM_W-1:0]  acc_r;
  logic signed [DET_W-1:0]  det_r;
  logic signed [NUM_W-1:0]  nx_r, ny_r;
  logic signed [OUT_W-1:0]  cx_r, cy_r;
  logic                     sat_r;
  logic signed [OUT_W-1:0]  out_x_r, out_y_r;
  logic                     out_par_r, out_sat_r, out_last_r;

  logic signed [A_W-1:0]    pa, pb, qa, qb;
  logic signed [C_W-1:0]    pc, qc;
  logic signed [C_W-1:0]    ma;
  logic signed [A_W-1:0]    mb;
  logic signed [PROD_W-1:0] prod_w;
  logic signed [NUM_W-1:0]  prod_ext;
  logic signed [NUM_W-1:0]  div_num;
  logic                     div_done;
  logic signed [OUT_W-1:0]  div_quo;
  logic                     div_sat;

  // Select the two lines of the corner being worked on.
  always_comb begin
    if (pair_sel_r == PAIR_PREV_CUR) begin
      pa = prev_a_r; pb = prev_b_r; pc = prev_c_r;
      qa = cur_a_r;  qb = cur_b_r;  qc = cur_c_r;
    end else begin
      pa = cur_a_r;   pb = cur_b_r;   pc = cur_c_r;
      qa = first_a_r; qb = first_b_r; qc = first_c_r;
    end
  end

  // Multiplier operands: the wide port takes c or a sign-extended a or b.
  always_comb begin
    case (cmd.mul_sel)
      MUL_AX: begin
        ma = {{(C_W-A_W){cur_a_r[A_W-1]}}, cur_a_r};
        mb = {1'b0, x1_r};
      end
      MUL_BY: begin
        ma = {{(C_W-A_W){cur_b_r[A_W-1]}}, cur_b_r};
        mb = {1'b0, y1_r};
      end
      MUL_PA_QB: begin
        ma = {{(C_W-A_W){pa[A_W-1]}}, pa};
        mb = qb;
      end
      MUL_QA_PB: begin
        ma = {{(C_W-A_W){qa[A_W-1]}}, qa};
        mb = pb;
      end
      MUL_PC_QB: begin
        ma = pc;
        mb = qb;
      end
      MUL_QC_PB: begin
        ma = qc;
        mb = pb;
      end
      MUL_QC_PA: begin
        ma = qc;
        mb = pa;
      end
      MUL_PC_QA: begin
        ma = pc;
        mb = qa;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod_w   = ma * mb;
  assign prod_ext = NUM_W'(prod_r);

  // Input capture, line storage and the product/accumulator pair.
  always_ff @(posedge clk) begin
    prod_r <= prod_w;
    if (cmd.cap) begin
      cur_a_r <= $signed({1'b0, in_end_y}) - $signed({1'b0, in_start_y});
      cur_b_r <= $signed({1'b0, in_start_x}) - $signed({1'b0, in_end_x});
      x1_r    <= in_start_x;
      y1_r    <= in_start_y;
      final_r <= in_final_segment;
    end
    case (cmd.acc_op)
      ACC_LOAD: acc_r <= prod_ext;
      ACC_ADD:  acc_r <= acc_r + prod_ext;
      ACC_SUB:  acc_r <= acc_r - prod_ext;
      default:  acc_r <= acc_r;
    endcase
    if (cmd.store_c) begin
      cur_c_r <= acc_r[C_W-1:0];
    end
    if (cmd.set_first) begin
      first_a_r <= cur_a_r;
      first_b_r <= cur_b_r;
      first_c_r <= cur_c_r;
    end
    if (cmd.set_prev) begin
      prev_a_r <= cur_a_r;
      prev_b_r <= cur_b_r;
      prev_c_r <= cur_c_r;
    end
    if (cmd.pair_load) begin
      pair_sel_r <= cmd.pair_sel;
    end
    if (cmd.store_det) begin
      det_r <= acc_r[DET_W-1:0];
    end
    if (cmd.store_nx) begin
      nx_r <= acc_r;
    end
    if (cmd.store_ny) begin
      ny_r <= acc_r;
    end
  end

  // Corner coordinates and the saturation flag gathered from the divider.
  always_ff @(posedge clk) begin
    if (cmd.corner_clear) begin
      cx_r  <= '0;
      cy_r  <= '0;
      sat_r <= 1'b0;
    end else begin
      if (cmd.cap_x) begin
        cx_r <= div_quo;
      end
      if (cmd.cap_y) begin
        cy_r <= div_quo;
      end
      if (cmd.cap_x || cmd.cap_y) begin
        sat_r <= sat_r | div_sat;
      end
    end
  end

  assign div_num = (cmd.div_sel == DIV_X) ? nx_r : ny_r;

  pcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (det_r),
    .done  (div_done),
    .quo   (div_quo),
    .sat   (div_sat)
  );

  // Output register; a parallel corner keeps the cleared coordinates.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_x_r    <= cx_r;
      out_y_r    <= cy_r;
      out_par_r  <= (det_r == '0);
      out_sat_r  <= sat_r;
      out_last_r <= (pair_sel_r == PAIR_CUR_FIRST);
    end
  end

  assign out_corner_x       = out_x_r;
  assign out_corner_y       = out_y_r;
  assign out_parallel_flag  = out_par_r;
  assign out_saturated_flag = out_sat_r;
  assign out_last_corner    = out_last_r;

  assign stat.final_seg = final_r;
  assign stat.det_zero  = (det_r == '0);
  assign stat.div_done  = div_done;
  assign stat.pair_sel  = pair_sel_r;

endmodule

// ----- sv/pcs_ctrl.sv -----
// ----------------------------------------------------------------------------
// pcs_ctrl: controller of the polygon corner block
// Sequences line setup, the Cramer products, the two divisions and the
// output transaction, and tracks the start of each polygon.
// ----------------------------------------------------------------------------
module pcs_ctrl import pcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output pcs_cmd_t  cmd,
  input  pcs_stat_t stat
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_LN_M0,
    S_LN_M1,
    S_LN_ACC,
    S_LN_ST,
    S_LN_DEC,
    S_K_M0,
    S_K_M1,
    S_K_M2,
    S_K_M3,
    S_K_M4,
    S_K_M5,
    S_K_M6,
    S_K_M7,
    S_K_DX,
    S_K_DY,
    S_K_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   have_first_r, have_first_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The output register can take a new corner when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    have_first_nxt = have_first_r;
    out_valid_nxt  = out_valid_r && out_stall;
    cmd            = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_LN_M0;
        end
      end
      // c = a*x1 + b*y1 through the shared multiplier.
      S_LN_M0: begin
        cmd.mul_sel = MUL_AX;
        state_nxt   = S_LN_M1;
      end
      S_LN_M1: begin
        cmd.mul_sel = MUL_BY;
        cmd.acc_op  = ACC_LOAD;
        state_nxt   = S_LN_ACC;
      end
      S_LN_ACC: begin
        cmd.acc_op = ACC_ADD;
        state_nxt  = S_LN_ST;
      end
      S_LN_ST: begin
        cmd.store_c = 1'b1;
        state_nxt   = S_LN_DEC;
      end
      // Either intersect with the previous line or record the first line; a lone final line is paired with itself.
      S_LN_DEC: begin
        if (have_first_r) begin
          cmd.pair_load    = 1'b1;
          cmd.pair_sel     = PAIR_PREV_CUR;
          cmd.corner_clear = 1'b1;
          state_nxt        = S_K_M0;
        end else begin
          cmd.set_first  = 1'b1;
          have_first_nxt = 1'b1;
          if (stat.final_seg) begin
            cmd.pair_load    = 1'b1;
            cmd.pair_sel     = PAIR_CUR_FIRST;
            cmd.corner_clear = 1'b1;
            state_nxt        = S_K_M0;
          end else begin
            cmd.set_prev = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
      end
      // Determinant and both numerators, one product per cycle.
      S_K_M0: begin
        cmd.mul_sel = MUL_PA_QB;
        state_nxt   = S_K_M1;
      end
      S_K_M1: begin
        cmd.mul_sel = MUL_QA_PB;
        cmd.acc_op  = ACC_LOAD;
        state_nxt   = S_K_M2;
      end
      S_K_M2: begin
        cmd.mul_sel = MUL_PC_QB;
        cmd.acc_op  = ACC_SUB;
        state_nxt   = S_K_M3;
      end
      S_K_M3: begin
        cmd.mul_sel   = MUL_QC_PB;
        cmd.store_det = 1'b1;
        cmd.acc_op    = ACC_LOAD;
        state_nxt     = S_K_M4;
      end
      S_K_M4: begin
        cmd.mul_sel = MUL_QC_PA;
        cmd.acc_op  = ACC_SUB;
        state_nxt   = S_K_M5;
      end
      S_K_M5: begin
        cmd.mul_sel  = MUL_PC_QA;
        cmd.store_nx = 1'b1;
        cmd.acc_op   = ACC_LOAD;
        state_nxt    = S_K_M6;
      end
      S_K_M6: begin
        cmd.acc_op = ACC_SUB;
        state_nxt  = S_K_M7;
      end
      // Parallel lines skip the divisions and leave zero coordinates.
      S_K_M7: begin
        cmd.store_ny = 1'b1;
        if (stat.det_zero) begin
          state_nxt = S_K_OUT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_X;
          state_nxt     = S_K_DX;
        end
      end
      S_K_DX: begin
        if (stat.div_done) begin
          cmd.cap_x     = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_Y;
          state_nxt     = S_K_DY;
        end
      end
      S_K_DY: begin
        cmd.div_sel = DIV_Y;
        if (stat.div_done) begin
          cmd.cap_y = 1'b1;
          state_nxt = S_K_OUT;
        end
      end
      // Hand the corner to the output register, then close the polygon if needed.
      S_K_OUT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          if (stat.pair_sel == PAIR_PREV_CUR && stat.final_seg) begin
            cmd.pair_load    = 1'b1;
            cmd.pair_sel     = PAIR_CUR_FIRST;
            cmd.corner_clear = 1'b1;
            state_nxt        = S_K_M0;
          end else begin
            cmd.set_prev = 1'b1;
            if (stat.final_seg) begin
              have_first_nxt = 1'b0;
            end
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      have_first_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      have_first_r <= have_first_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- sv/polygon_corners_from_segments.sv -----
// ----------------------------------------------------------------------------
// A corner is offered once its segment has gone through line setup, the Cramer
// products, two divisions (one quotient bit per cycle) and the output step; a
// parallel pair skips the divisions. The block takes one segment at a time:
// in_stall stays high until the segment and its corners are done, and a stall
// on the result channel holds the block.
// Reset (rst_n low, synchronous) empties the output register and starts a new polygon.
// ----------------------------------------------------------------------------
// polygon_corners_from_segments: top level
// Turns a closed run of segments into polygon corners by Cramer's rule.
// ----------------------------------------------------------------------------
module polygon_corners_from_segments import pcs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [COORD_BITS-1:0]   in_start_x,
  input  logic [COORD_BITS-1:0]   in_start_y,
  input  logic [COORD_BITS-1:0]   in_end_x,
  input  logic [COORD_BITS-1:0]   in_end_y,
  input  logic                    in_final_segment,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_corner_x,
  output logic signed [OUT_W-1:0] out_corner_y,
  output logic                    out_parallel_flag,
  output logic                    out_saturated_flag,
  output logic                    out_last_corner
);

  pcs_cmd_t  cmd;
  pcs_stat_t stat;

  // Sequencer.
  pcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Arithmetic and storage.
  pcs_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_start_x         (in_start_x),
    .in_start_y         (in_start_y),
    .in_end_x           (in_end_x),
    .in_end_y           (in_end_y),
    .in_final_segment   (in_final_segment),
    .out_corner_x       (out_corner_x),
    .out_corner_y       (out_corner_y),
    .out_parallel_flag  (out_parallel_flag),
    .out_saturated_flag (out_saturated_flag),
    .out_last_corner    (out_last_corner)
  );

endmodule
